/* design/seeded_shuffle_sampler_unit_macros.svh */
// assertion macros for the shuffle sampler
`ifndef SEEDED_SHUFFLE_SAMPLER_UNIT_MACROS_SVH
`define SEEDED_SHUFFLE_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssu assertion failed");

// next-cycle implication, checked out of reset
`define SSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssu assertion failed");

`endif

/* design/ssu_pkg.sv */
// shared types and constants of the shuffle sampler
package ssu_pkg;

    localparam int unsigned SSU_MAX_ITEMS = 16384;

    localparam logic [63:0] SSU_SEED_RESET   = 64'd20260728;
    localparam logic [14:0] SSU_SAMPLE_RESET = 15'd4096;

    localparam logic [63:0] SSU_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SSU_MIX_C1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SSU_MIX_C2 = 64'h94D049BB133111EB;

    localparam logic [7:0] SSU_REG_SEED   = 8'd0;
    localparam logic [7:0] SSU_REG_SAMPLE = 8'd1;

    localparam logic SSU_MODE_START = 1'b0;
    localparam logic SSU_MODE_READ  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [14:0] total_items;
        logic [13:0] position;
    } t_in_item;

    typedef struct packed {
        logic [13:0] picked_index;
        logic        valid_res;
        logic [14:0] selected_count;
    } t_out_item;

endpackage

/* design/ssu_ram.sv */
// generic single write port ram with registered read
module ssu_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/seeded_shuffle_sampler_unit.sv */
// top level of the seeded shuffle sampler
// A start transfer (mode 0) rebuilds a seeded random permutation of 0..total-1
// in an internal ram and answers with the selected count; a read transfer
// (mode 1) returns the index held at one position. A read goes through the ram
// read issued at transfer, the capture state and the response state before the
// output register (no ram read or capture when the position is outside the sample).
// A start does one ram write per entry for the identity fill, then per swap
// step one generator add, two 64-bit multiplies done as three 32x32 partial
// products on one shared multiplier, a bit-serial modulo by the current length,
// and a swap through the single read and single write port: two reads, then
// two writes. The divider dominates. The block takes no new item until the
// current one has moved its result to the output register; the output register
// lets the next item start while a result waits to be taken.
`include "seeded_shuffle_sampler_unit_macros.svh"

module seeded_shuffle_sampler_unit
    import ssu_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = SSU_MAX_ITEMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned XW = (CW > 15) ? CW : 15;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_MIX  = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_XS   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_SW0  = 4'd6;
    localparam logic [3:0] ST_SW1  = 4'd7;
    localparam logic [3:0] ST_SW2  = 4'd8;
    localparam logic [3:0] ST_SW3  = 4'd9;
    localparam logic [3:0] ST_RDX  = 4'd10;
    localparam logic [3:0] ST_RESP = 4'd11;

    logic [3:0]    r_state;
    logic [63:0]   r_seed;
    logic [14:0]   r_sample;
    logic [14:0]   r_sel;
    logic [63:0]   r_rng;
    logic [63:0]   r_z;
    logic [63:0]   r_acc;
    logic [63:0]   r_prod;
    logic          r_pass;
    logic [5:0]    r_cnt;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_rem;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_r;
    logic [IW-1:0] r_ta;
    logic [13:0]   r_pick;
    logic          r_ok;
    logic          r_ovld;
    t_out_item     r_out;

    logic          in_xfer;
    logic          out_free;
    logic [XW-1:0] tot_x;
    logic [XW-1:0] max_x;
    logic [CW-1:0] tsat;
    logic          rd_ok;
    logic [XW-1:0] smp_x;
    logic [XW-1:0] jt_x;
    logic [63:0]   n_sum;
    logic [63:0]   m_b;
    logic [31:0]   m_op_a;
    logic [31:0]   m_op_b;
    logic [CW:0]   div_t;
    logic [CW-1:0] n_rem;
    logic [IW-1:0] j_dec;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_ovld || i_out_ready;

    assign tot_x = XW'(i_in.total_items);
    assign max_x = XW'(MAX_ITEMS);
    assign tsat  = CW'((tot_x > max_x) ? max_x : tot_x);
    assign rd_ok = XW'(i_in.position) < XW'(r_sel);
    assign smp_x = XW'(r_sample);
    assign jt_x  = XW'(r_total);

    assign n_sum = r_rng + SSU_GOLDEN;
    assign m_b   = r_pass ? SSU_MIX_C2 : SSU_MIX_C1;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd1: begin
                m_op_a = r_z[63:32];
                m_op_b = m_b[31:0];
            end
            2'd2: begin
                m_op_a = r_z[31:0];
                m_op_b = m_b[63:32];
            end
            default: begin
                m_op_a = r_z[31:0];
                m_op_b = m_b[31:0];
            end
        endcase
    end

    assign div_t = {r_rem, r_z[63]};
    assign n_rem = (div_t >= {1'b0, r_j}) ? CW'(div_t - {1'b0, r_j}) : CW'(div_t);
    assign j_dec = IW'(r_j - CW'(1));

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = r_k;
        ram_re    = 1'b0;
        ram_raddr = IW'(i_in.position);
        unique case (r_state)
            ST_IDLE: begin
                ram_re = in_xfer && (i_in.mode == SSU_MODE_READ) && rd_ok;
            end
            ST_FILL: begin
                ram_we = 1'b1;
            end
            ST_SW0: begin
                ram_re    = 1'b1;
                ram_raddr = j_dec;
            end
            ST_SW1: begin
                ram_re    = 1'b1;
                ram_raddr = r_r;
            end
            ST_SW2: begin
                ram_we    = 1'b1;
                ram_waddr = j_dec;
                ram_wdata = ram_rdata;
            end
            ST_SW3: begin
                ram_we    = 1'b1;
                ram_waddr = r_r;
                ram_wdata = r_ta;
            end
            default: begin
            end
        endcase
    end

    ssu_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ITEMS)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= SSU_SEED_RESET;
            r_sample <= SSU_SAMPLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == SSU_REG_SEED) begin
                r_seed <= i_cfg_data;
            end else if (i_cfg_index == SSU_REG_SAMPLE) begin
                r_sample <= i_cfg_data[14:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (r_state == ST_RESP && out_free) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && out_free) begin
            r_out.picked_index   <= r_pick;
            r_out.valid_res      <= r_ok;
            r_out.selected_count <= r_sel;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_pick <= '0;
                        if (i_in.mode == SSU_MODE_START) begin
                            r_ok <= 1'b0;
                            if (tsat != '0) begin
                                r_rng   <= r_seed;
                                r_total <= tsat;
                                r_j     <= tsat;
                                r_k     <= '0;
                                r_state <= ST_FILL;
                            end else begin
                                r_state <= ST_RESP;
                            end
                        end else begin
                            r_ok    <= rd_ok;
                            r_state <= rd_ok ? ST_RDX : ST_RESP;
                        end
                    end
                end
                ST_FILL: begin
                    r_k <= r_k + IW'(1);
                    if (r_k == IW'(r_total - CW'(1))) begin
                        if (r_total > CW'(1)) begin
                            r_state <= ST_MIX;
                        end else begin
                            r_sel   <= 15'((smp_x < jt_x) ? smp_x : jt_x);
                            r_ok    <= 1'b1;
                            r_state <= ST_RESP;
                        end
                    end
                end
                ST_MIX: begin
                    r_rng   <= n_sum;
                    r_z     <= n_sum ^ (n_sum >> 30);
                    r_pass  <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod <= m_op_a * m_op_b;
                    r_cnt  <= r_cnt + 6'd1;
                    unique case (r_cnt[1:0])
                        2'd0: begin
                        end
                        2'd1: begin
                            r_acc <= r_prod;
                        end
                        2'd2: begin
                            r_acc <= r_acc + {r_prod[31:0], 32'b0};
                        end
                        default: begin
                            r_z     <= r_acc + {r_prod[31:0], 32'b0};
                            r_state <= ST_XS;
                        end
                    endcase
                end
                ST_XS: begin
                    r_cnt <= '0;
                    if (!r_pass) begin
                        r_z     <= r_z ^ (r_z >> 27);
                        r_pass  <= 1'b1;
                        r_state <= ST_MUL;
                    end else begin
                        r_z     <= r_z ^ (r_z >> 31);
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_z   <= r_z << 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_r     <= IW'(n_rem);
                        r_state <= ST_SW0;
                    end
                end
                ST_SW0: begin
                    r_state <= ST_SW1;
                end
                ST_SW1: begin
                    r_ta    <= ram_rdata;
                    r_state <= ST_SW2;
                end
                ST_SW2: begin
                    r_state <= ST_SW3;
                end
                ST_SW3: begin
                    r_j <= r_j - CW'(1);
                    if (r_j == CW'(2)) begin
                        r_sel   <= 15'((smp_x < jt_x) ? smp_x : jt_x);
                        r_ok    <= 1'b1;
                        r_state <= ST_RESP;
                    end else begin
                        r_state <= ST_MIX;
                    end
                end
                ST_RDX: begin
                    r_pick  <= 14'(ram_rdata);
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `SSU_ASSERT_NOW(a_rem_below_len, r_state == ST_DIV, r_rem < r_j)
    `SSU_ASSERT_NOW(a_partner_below_len, r_state == ST_SW3, CW'(r_r) < r_j)
    `SSU_ASSERT_NOW(a_mix_len_min, r_state == ST_MIX, r_j >= CW'(2))
    `SSU_ASSERT_NEXT(a_resp_loads_out, (r_state == ST_RESP) && out_free, r_ovld)

endmodule

/* sim/tb.sv */
// self-checking testbench for the seeded shuffle sampler with its own permutation predictor
`timescale 1ns / 1ps

module tb;
    import ssu_pkg::*;

    localparam int unsigned IDLE_LIMIT = 5_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    seeded_shuffle_sampler_unit dut (.*);

    // predictor state
    logic [13:0] perm_mem [SSU_MAX_ITEMS];
    logic [63:0] mix_state = '0;
    logic [14:0] perm_total = '0;
    logic [14:0] picked_span = '0;
    logic [63:0] seed_reg = SSU_SEED_RESET;
    logic [14:0] sample_reg = SSU_SAMPLE_RESET;

    t_out_item   pending_results [$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_phase = 0;
    int unsigned stall_style = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mix_next();
        logic [63:0] z;
        mix_state = mix_state + SSU_GOLDEN;
        z = mix_state;
        z = (z ^ (z >> 30)) * SSU_MIX_C1;
        z = (z ^ (z >> 27)) * SSU_MIX_C2;
        return z ^ (z >> 31);
    endfunction

    function automatic t_out_item predict_item(t_in_item it);
        t_out_item   res;
        logic [14:0] total;
        logic [13:0] swap_tmp;
        logic [63:0] pick;
        res = '0;
        if (it.mode == SSU_MODE_START) begin
            total = it.total_items;
            if (total != 0) begin
                if (total > SSU_MAX_ITEMS) total = 15'(SSU_MAX_ITEMS);
                mix_state = seed_reg;
                for (int j = 0; j < total; j++) perm_mem[j] = 14'(j);
                for (int j = total; j > 1; j--) begin
                    pick = mix_next() % 64'(j);
                    swap_tmp = perm_mem[j-1];
                    perm_mem[j-1] = perm_mem[pick];
                    perm_mem[pick] = swap_tmp;
                end
                perm_total = total;
                picked_span = (sample_reg < total) ? sample_reg : total;
                res.valid_res = 1'b1;
            end
        end else if (it.position < picked_span && it.position < perm_total) begin
            res.picked_index = perm_mem[it.position];
            res.valid_res = 1'b1;
        end
        res.selected_count = picked_span;
        return res;
    endfunction

    task automatic send_item(t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        pending_results.push_back(predict_item(it));
    endtask

    task automatic send_start(logic [14:0] total);
        t_in_item it;
        it = '0;
        it.mode = SSU_MODE_START;
        it.total_items = total;
        it.position = 14'($urandom);
        send_item(it);
    endtask

    task automatic send_read(logic [13:0] pos);
        t_in_item it;
        it = '0;
        it.mode = SSU_MODE_READ;
        it.position = pos;
        it.total_items = 15'($urandom);
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [63:0] data);
        drain();
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (idx == SSU_REG_SEED) seed_reg = data;
        else if (idx == SSU_REG_SAMPLE) sample_reg = data[14:0];
    endtask

    // receiver with its own stall pattern and a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: actual %p", $time, o_out);
                error_count++;
            end else begin
                t_out_item want;
                want = pending_results.pop_front();
                if (o_out.picked_index !== want.picked_index) begin
                    $display("%0t picked_index expected %0d actual %0d",
                             $time, want.picked_index, o_out.picked_index);
                    error_count++;
                end
                if (o_out.valid_res !== want.valid_res) begin
                    $display("%0t valid_res expected %0d actual %0d",
                             $time, want.valid_res, o_out.valid_res);
                    error_count++;
                end
                if (o_out.selected_count !== want.selected_count) begin
                    $display("%0t selected_count expected %0d actual %0d",
                             $time, want.selected_count, o_out.selected_count);
                    error_count++;
                end
            end
        end
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= 600;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_style <= $urandom_range(0, 3);
                stall_phase <= $urandom_range(20, 120);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_style)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    i_out_ready <= stall_phase[0];
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 9) < 2);
                end
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_reads_before_start();
        send_read(14'd0);
        send_read(14'h3FFF);
        send_start(15'd0);
        send_read(14'd0);
    endtask

    task automatic test_small_starts();
        send_start(15'd1);
        send_read(14'd0);
        send_read(14'd1);
        write_reg(SSU_REG_SEED, 64'd0);
        send_start(15'd2);
        send_read(14'd0);
        send_read(14'd1);
        send_read(14'd2);
        send_start(15'd0);
        send_read(14'd1);
    endtask

    task automatic test_zero_sample();
        write_reg(SSU_REG_SAMPLE, 64'd0);
        send_start(15'd10);
        send_read(14'd0);
        write_reg(SSU_REG_SAMPLE, 64'd5);
        send_read(14'd0);
    endtask

    task automatic test_saturated_start();
        write_reg(SSU_REG_SEED, {64{1'b1}});
        write_reg(SSU_REG_SAMPLE, 64'(SSU_MAX_ITEMS));
        send_start(15'h7FFF);
        send_read(14'd0);
        send_read(14'h3FFF);
        send_read(14'h2AAA);
        write_reg(SSU_REG_SAMPLE, 64'd3);
        send_read(14'd100);
        send_read(14'h1555);
    endtask

    task automatic test_random_phases();
        int unsigned sent;
        int unsigned n_reads;
        logic [14:0] total;
        sent = 0;
        while (sent < 1600) begin
            if ($urandom_range(0, 2) == 0) write_reg(SSU_REG_SEED, {$urandom, $urandom});
            case ($urandom_range(0, 5))
                0: write_reg(SSU_REG_SAMPLE, 64'd0);
                1: write_reg(SSU_REG_SAMPLE, 64'(SSU_MAX_ITEMS));
                2: write_reg(SSU_REG_SAMPLE, 64'($urandom_range(0, 32767)));
                default: write_reg(SSU_REG_SAMPLE, 64'($urandom_range(1, 80)));
            endcase
            total = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 400))
                                                : 15'($urandom_range(1, 64));
            send_start(total);
            sent++;
            n_reads = $urandom_range(20, 70);
            for (int k = 0; k < n_reads; k++) begin
                case ($urandom_range(0, 19))
                    0: send_read(14'($urandom));
                    1: send_read(14'(picked_span));
                    2: send_start(15'd0);
                    default: send_read(14'($urandom_range(0, total + 2)));
                endcase
                sent++;
            end
        end
    endtask

    task automatic test_output_hold();
        drain();
        write_reg(SSU_REG_SAMPLE, 64'd40);
        send_start(15'd40);
        drain();
        hold_toggle = ~hold_toggle;
        for (int k = 0; k < 50; k++) send_read(14'($urandom_range(0, 45)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reads_before_start();
        test_small_starts();
        test_zero_sample();
        test_saturated_start();
        test_output_hold();
        test_random_phases();
        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
